// ===== sv/pps_pkg.sv =====
`default_nettype none
package pps_pkg;
   localparam int MaxPoints = 1024;
   localparam int IdxW = 10;
   localparam int AngleSteps = 16;
   localparam logic [31:0] InvGain = 32'd652032875;

   typedef enum logic {CMD_LOAD = 1'b0, CMD_SAMPLE = 1'b1} cmd_type;

   // byte address of the last_index register
   localparam logic [1:0] RegLastIndex = 2'd0;

   // arctangent table, binary angle, 2^32 per turn
   function automatic logic [31:0] arc_tab(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
         5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
         5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
         5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
         5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001; default: r = 32'h00000000;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== sv/pps_lerp.sv =====
`default_nettype none
// Two-stage linear interpolation: v1 + round((v2-v1)*f/65536)
module pps_lerp (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   input  wire logic [15:0] f,
   output logic      [33:0] result
);
   logic signed [32:0] d_ff, d_in;
   logic signed [31:0] v1_ff, v1p_ff;
   logic [15:0] f_ff;
   logic signed [50:0] prod_ff, prod_in;

   assign d_in = $signed({b[31], b}) - $signed({a[31], a});
   assign prod_in = d_ff * $signed({1'b0, f_ff});

   // hold difference, then product
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         v1_ff   <= a;
         f_ff    <= f;
         prod_ff <= prod_in;
         v1p_ff  <= v1_ff;
      end
   end

   logic signed [50:0] rnd;
   assign rnd = (prod_ff + 51'sd32768) >>> 16;
   assign result = 34'($signed({{2{v1p_ff[31]}}, v1p_ff}) + $signed(rnd[33:0]));
endmodule
`default_nettype wire

// ===== sv/path_pose_sampler.sv =====
`default_nettype none
// Pipeline: memory read at the accepting edge, then 2 interpolate, 1 atan2 pre-rotation,
// 16 atan2 CORDIC stages, 1 angle fold, 16 sin/cos CORDIC stages, 1 output round,
// 1 queue write, 1 queue read. Throughput: one word per cycle while req_tready is high,
// set by the fully pipelined CORDIC stages; the queue read waits on a held output.
// Reset: synchronous; clears last_index, all valid flags and the result queue. The point
// memories are not cleared and hold undefined data until loaded.
module path_pose_sampler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command, point_index, point_x, point_y, point_z, tangent_x, tangent_y,
   // tangent_z, path_position (lowest first), zero fill to 232 bits
   input  wire logic [231:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // translate_x, translate_y, translate_z, rotation_y_part, rotation_w_part,
   // clamp_flag (lowest first), zero fill to 136 bits
   output logic      [135:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import pps_pkg::*;

   localparam int Lat = 2 + 2 + AngleSteps + 1 + AngleSteps + 1;
   localparam int FifoD = 64;
   localparam int FifoW = 6;

   // unpack word
   logic            cmd;
   logic [IdxW-1:0] pidx;
   logic [31:0]     px, py, pz, tx, tz;
   logic [25:0]     ppos;
   assign cmd  = req_tdata[0];
   assign pidx = req_tdata[10:1];
   assign px   = req_tdata[42:11];
   assign py   = req_tdata[74:43];
   assign pz   = req_tdata[106:75];
   assign tx   = req_tdata[138:107];
   assign tz   = req_tdata[202:171];
   assign ppos = req_tdata[228:203];

   // configuration
   logic [IdxW-1:0] last_index_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegLastIndex) ? {22'd0, last_index_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         last_index_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == RegLastIndex) begin
         last_index_ff <= csr_pwdata[IdxW-1:0];
      end
   end

   // output queue with credit count so every accepted sample has a slot
   logic [FifoW:0] cnt_ff, cnt_in;
   logic [FifoW-1:0] wp_ff, rp_ff;
   logic [135:0] fifo_mem [FifoD];
   logic [135:0] out_ff;
   logic         out_vld_ff;
   logic         acc, pop, push, rd;
   logic [FifoW:0] infl_ff, infl_in;

   assign req_tready = (32'(cnt_ff) + 32'(out_vld_ff) + 32'(infl_ff)) < FifoD;
   assign acc = req_tvalid && req_tready;
   assign pop = rsp_tvalid && rsp_tready;

   // address decode and clamping
   logic [IdxW-1:0] i0, i1;
   logic [IdxW:0]   i1w;
   logic            clamped;
   logic [15:0]     frac;
   assign frac = ppos[15:0];
   always_comb begin
      i0 = ppos[25:16];
      i1w = {1'b0, ppos[25:16]} + {{IdxW{1'b0}}, (frac != 16'd0)};
      clamped = 1'b0;
      if (i0 > last_index_ff) begin
         i0 = last_index_ff;
         clamped = 1'b1;
      end
      if (i1w > {1'b0, last_index_ff}) begin
         i1 = last_index_ff;
         clamped = 1'b1;
      end else begin
         i1 = i1w[IdxW-1:0];
      end
   end

   // point memories, two read ports (A and B banks mirror writes, one read port each)
   logic [159:0] mem_a [MaxPoints];
   logic [159:0] mem_b [MaxPoints];
   logic [159:0] rd_a_ff, rd_b_ff;
   logic         wr;
   assign wr = acc && cmd == CMD_LOAD;
   always_ff @(posedge clock) begin
      if (wr) begin
         mem_a[pidx] <= {tz, tx, pz, py, px};
         mem_b[pidx] <= {tz, tx, pz, py, px};
      end
      rd_a_ff <= mem_a[i0];
      rd_b_ff <= mem_b[i1];
   end

   // sideband pipeline: valid, fraction, clamp
   logic [Lat-1:0]   vld_ff;
   logic [15:0]      f_ff;
   logic [Lat-1:0]   clp_ff;
   logic             smp;
   assign smp = acc && cmd == CMD_SAMPLE;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Lat-2:0], smp};
      end
      clp_ff <= {clp_ff[Lat-2:0], clamped};
      f_ff <= frac;
   end

   // interpolation
   logic [33:0] lx, ly, lz, ltx, ltz;
   pps_lerp u_lx (.clock, .en(1'b1), .a(rd_a_ff[31:0]), .b(rd_b_ff[31:0]),
                  .f(f_ff), .result(lx));
   pps_lerp u_ly (.clock, .en(1'b1), .a(rd_a_ff[63:32]), .b(rd_b_ff[63:32]),
                  .f(f_ff), .result(ly));
   pps_lerp u_lz (.clock, .en(1'b1), .a(rd_a_ff[95:64]), .b(rd_b_ff[95:64]),
                  .f(f_ff), .result(lz));
   pps_lerp u_ltx (.clock, .en(1'b1), .a(rd_a_ff[127:96]), .b(rd_b_ff[127:96]),
                   .f(f_ff), .result(ltx));
   pps_lerp u_ltz (.clock, .en(1'b1), .a(rd_a_ff[159:128]), .b(rd_b_ff[159:128]),
                   .f(f_ff), .result(ltz));

   // translation delay line to output, matched to pre-rotation, both CORDICs and round
   localparam int TDel = AngleSteps + 1 + AngleSteps + 2;
   logic [95:0] tr_ff [TDel];
   always_ff @(posedge clock) begin
      tr_ff[0] <= {lz[31:0], ly[31:0], lx[31:0]};
      for (int k = 1; k < TDel; k++) tr_ff[k] <= tr_ff[k-1];
   end

   // atan2 vectoring CORDIC, one stage per step
   logic signed [37:0] ax_ff [AngleSteps+1];
   logic signed [37:0] az_ff [AngleSteps+1];
   logic [31:0]        aa_ff [AngleSteps+1];
   logic               zero_ff [AngleSteps+1];
   always_ff @(posedge clock) begin
      zero_ff[0] <= (ltx == 34'd0) && (ltz == 34'd0);
      if ($signed(ltx) < 0) begin
         ax_ff[0] <= -38'($signed(ltx));
         az_ff[0] <= -38'($signed(ltz));
         aa_ff[0] <= 32'h80000000;
      end else begin
         ax_ff[0] <= 38'($signed(ltx));
         az_ff[0] <= 38'($signed(ltz));
         aa_ff[0] <= 32'd0;
      end
      for (int s = 0; s < AngleSteps; s++) begin
         zero_ff[s+1] <= zero_ff[s];
         if (az_ff[s] >= 0) begin
            ax_ff[s+1] <= ax_ff[s] + (az_ff[s] >>> s);
            az_ff[s+1] <= az_ff[s] - (ax_ff[s] >>> s);
            aa_ff[s+1] <= aa_ff[s] + arc_tab(5'(s));
         end else begin
            ax_ff[s+1] <= ax_ff[s] - (az_ff[s] >>> s);
            az_ff[s+1] <= az_ff[s] + (ax_ff[s] >>> s);
            aa_ff[s+1] <= aa_ff[s] - arc_tab(5'(s));
         end
      end
   end

   // half angle, offset, fold
   logic [31:0] ang, half;
   logic signed [32:0] sa, fa;
   logic        fneg;
   assign ang  = zero_ff[AngleSteps] ? 32'd0 : aa_ff[AngleSteps];
   assign half = {ang[31], ang[31:1]} + 32'h60000000;
   always_comb begin
      sa = $signed({half[31], half});
      fneg = 1'b0;
      fa = sa;
      if (sa > 33'sh040000000) begin
         fa = sa - 33'sh080000000;
         fneg = 1'b1;
      end else if (sa < -33'sh040000000) begin
         fa = sa + 33'sh080000000;
         fneg = 1'b1;
      end
   end

   // sin/cos rotation CORDIC
   logic signed [33:0] sx_ff [AngleSteps+1];
   logic signed [33:0] sy_ff [AngleSteps+1];
   logic signed [33:0] sz_ff [AngleSteps+1];
   logic               sn_ff [AngleSteps+1];
   always_ff @(posedge clock) begin
      sx_ff[0] <= 34'($signed({1'b0, InvGain}));
      sy_ff[0] <= '0;
      sz_ff[0] <= 34'(fa);
      sn_ff[0] <= fneg;
      for (int s = 0; s < AngleSteps; s++) begin
         sn_ff[s+1] <= sn_ff[s];
         if (sz_ff[s] >= 0) begin
            sx_ff[s+1] <= sx_ff[s] - (sy_ff[s] >>> s);
            sy_ff[s+1] <= sy_ff[s] + (sx_ff[s] >>> s);
            sz_ff[s+1] <= sz_ff[s] - $signed({2'b00, arc_tab(5'(s))});
         end else begin
            sx_ff[s+1] <= sx_ff[s] + (sy_ff[s] >>> s);
            sy_ff[s+1] <= sy_ff[s] - (sx_ff[s] >>> s);
            sz_ff[s+1] <= sz_ff[s] + $signed({2'b00, arc_tab(5'(s))});
         end
      end
   end

   function automatic logic [15:0] to_q15(input logic signed [34:0] v);
      logic signed [34:0] r;
      r = (v + 35'sd16384) >>> 15;
      if (r > 35'sd32767) return 16'h7FFF;
      if (r < -35'sd32768) return 16'h8000;
      return r[15:0];
   endfunction

   logic signed [34:0] fx, fy;
   logic [15:0] qs_ff, qc_ff;
   assign fx = sn_ff[AngleSteps] ? -35'(sx_ff[AngleSteps]) : 35'(sx_ff[AngleSteps]);
   assign fy = sn_ff[AngleSteps] ? -35'(sy_ff[AngleSteps]) : 35'(sy_ff[AngleSteps]);
   always_ff @(posedge clock) begin
      qs_ff <= to_q15(fy);
      qc_ff <= to_q15(fx);
   end

   // result queue: memory with registered read into the output word
   assign push = vld_ff[Lat-1];
   assign rd = (cnt_ff != '0) && (!out_vld_ff || pop);
   always_comb begin
      cnt_in = cnt_ff + {{FifoW{1'b0}}, push} - {{FifoW{1'b0}}, rd};
      infl_in = infl_ff + {{FifoW{1'b0}}, smp} - {{FifoW{1'b0}}, push};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         infl_ff <= '0;
         wp_ff <= '0;
         rp_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         infl_ff <= infl_in;
         if (push) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         if (rd) out_vld_ff <= 1'b1;
         else if (pop) out_vld_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (push)
         fifo_mem[wp_ff] <= {7'd0, clp_ff[Lat-1], qc_ff, qs_ff, tr_ff[TDel-1]};
      if (rd)
         out_ff <= fifo_mem[rp_ff];
   end
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_ff;
endmodule
`default_nettype wire
